@@ hw/rtl/tccw_pkg.sv @@
package tccw_pkg;

    // default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // fixed field widths
    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int COL_W  = 4;
    localparam int POS_W  = 11;
    localparam int CELL_W = 16;

    // character codes with their own handling
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    // blank cell: space with light gray on black
    localparam logic [CHAR_W-1:0] ATTR_BLANK = 8'h07;
    localparam logic [CELL_W-1:0] BLANK_CELL = {ATTR_BLANK, CH_SPACE};

    localparam int TAB_WIDTH = 4;
    localparam int TAB_IW    = $clog2(TAB_WIDTH);

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_SET   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LINE,
        ST_TAB,
        ST_CHECK,
        ST_SCROLL,
        ST_FILL,
        ST_READ,
        ST_DONE
    } t_state;

endpackage

@@ hw/rtl/text_console_char_writer_unit.sv @@
// sequence: an item is run in EXEC; put goes on through CHECK, read cell through READ, set
// cursor straight to DONE; tab writes its spaces in TAB, newline walks LINE (row start search
// one row a cycle), a scroll copies in SCROLL, clear blanks in FILL, by the single write port
// throughput: one item at a time, taken while the previous result waits in the output register
// reset: synchronous active low; then a clearing pass over all COLUMNS*ROWS cells blanks the
// cell memory while no input is taken, cursor starts at zero
module text_console_char_writer_unit #(
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // character[7:0], fg_color[11:8], bg_color[15:12], position[26:16], zero pad
    input  logic [31:0] i_s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // cursor_now[10:0], cell_char[18:11], cell_attr[26:19], did_scroll[27], zero pad
    output logic [31:0] o_m_axis_tdata
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int LIMIT      = CELL_COUNT - COLUMNS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int CW         = $clog2(CELL_COUNT + tccw_pkg::TAB_WIDTH);

    // state and control
    tccw_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_cursor, n_cursor;
    logic [CW-1:0]    r_base, n_base;
    logic [AW-1:0]    r_k, n_k;
    logic [tccw_pkg::TAB_IW-1:0] r_tab_i, n_tab_i;
    logic             r_emit, n_emit;
    logic             r_scrolled, n_scrolled;
    logic             r_pend_valid, n_pend_valid;
    logic             r_pend_copy, n_pend_copy;
    logic [AW-1:0]    r_pend_addr, n_pend_addr;
    logic             r_out_valid, n_out_valid;
    logic [31:0]      r_out_data, n_out_data;

    // captured item
    tccw_pkg::t_op    r_op;
    logic [7:0]       r_char;
    logic [7:0]       r_attr;
    logic [AW-1:0]    r_pos;
    logic [7:0]       r_res_char, n_res_char;
    logic [7:0]       r_res_attr, n_res_attr;

    // cell memory
    logic [tccw_pkg::CELL_W-1:0] r_mem [CELL_COUNT];
    logic [tccw_pkg::CELL_W-1:0] r_rd_data;
    logic                        w_we, w_re;
    logic [AW-1:0]               w_waddr, w_raddr;
    logic [tccw_pkg::CELL_W-1:0] w_wdata;

    logic [10:0]   w_pos_in;
    logic [CW-1:0] w_next_base;
    logic [CW-1:0] w_tab_addr;
    logic          w_accept;
    logic          w_out_free;

    assign w_pos_in    = i_s_axis_tdata[26:16];
    assign w_next_base = r_base + CW'(COLUMNS);
    assign w_tab_addr  = r_cursor + CW'(r_tab_i);
    assign w_accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free  = !r_out_valid || i_m_axis_tready;

    assign o_s_axis_tready = (r_state == tccw_pkg::ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    // item capture with position clamp
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= tccw_pkg::t_op'(i_s_axis_tuser);
            r_char <= i_s_axis_tdata[7:0];
            r_attr <= {i_s_axis_tdata[15:12], i_s_axis_tdata[11:8]};
            if (32'(w_pos_in) >= 32'(CELL_COUNT)) begin
                r_pos <= AW'(CELL_COUNT - 1);
            end else begin
                r_pos <= AW'(w_pos_in);
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tccw_pkg::ST_FILL;
            r_cursor     <= '0;
            r_base       <= '0;
            r_k          <= '0;
            r_tab_i      <= '0;
            r_emit       <= 1'b0;
            r_scrolled   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_pend_copy  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cursor     <= n_cursor;
            r_base       <= n_base;
            r_k          <= n_k;
            r_tab_i      <= n_tab_i;
            r_emit       <= n_emit;
            r_scrolled   <= n_scrolled;
            r_pend_valid <= n_pend_valid;
            r_pend_copy  <= n_pend_copy;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pend_addr <= n_pend_addr;
        r_out_data  <= n_out_data;
        r_res_char  <= n_res_char;
        r_res_attr  <= n_res_attr;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tccw_pkg::ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = tccw_pkg::ST_EXEC;
                end
            end
            tccw_pkg::ST_EXEC: begin
                case (r_op)
                    tccw_pkg::OP_PUT: begin
                        if (r_char == tccw_pkg::CH_NEWLINE) begin
                            n_state = tccw_pkg::ST_LINE;
                        end else if (r_char == tccw_pkg::CH_TAB) begin
                            n_state = tccw_pkg::ST_TAB;
                        end else begin
                            n_state = tccw_pkg::ST_CHECK;
                        end
                    end
                    tccw_pkg::OP_SET:   n_state = tccw_pkg::ST_DONE;
                    tccw_pkg::OP_CLEAR: n_state = tccw_pkg::ST_FILL;
                    tccw_pkg::OP_READ:  n_state = tccw_pkg::ST_READ;
                    default:            n_state = tccw_pkg::ST_DONE;
                endcase
            end
            tccw_pkg::ST_LINE: begin
                if (w_next_base > r_cursor) begin
                    n_state = tccw_pkg::ST_CHECK;
                end
            end
            tccw_pkg::ST_TAB: begin
                if (r_tab_i == tccw_pkg::TAB_IW'(tccw_pkg::TAB_WIDTH - 1)) begin
                    n_state = tccw_pkg::ST_CHECK;
                end
            end
            tccw_pkg::ST_CHECK: begin
                if (r_cursor >= CW'(CELL_COUNT)) begin
                    n_state = tccw_pkg::ST_SCROLL;
                end else begin
                    n_state = tccw_pkg::ST_DONE;
                end
            end
            tccw_pkg::ST_SCROLL: begin
                if (r_k == AW'(CELL_COUNT - 1)) begin
                    n_state = tccw_pkg::ST_DONE;
                end
            end
            tccw_pkg::ST_FILL: begin
                if (r_k == AW'(CELL_COUNT - 1)) begin
                    n_state = r_emit ? tccw_pkg::ST_DONE : tccw_pkg::ST_IDLE;
                end
            end
            tccw_pkg::ST_READ: n_state = tccw_pkg::ST_DONE;
            tccw_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = tccw_pkg::ST_IDLE;
                end
            end
            default: n_state = tccw_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_cursor     = r_cursor;
        n_base       = r_base;
        n_k          = r_k;
        n_tab_i      = r_tab_i;
        n_emit       = r_emit;
        n_scrolled   = r_scrolled;
        n_res_char   = r_res_char;
        n_res_attr   = r_res_attr;
        n_pend_valid = 1'b0;
        n_pend_copy  = r_pend_copy;
        n_pend_addr  = r_pend_addr;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_data   = r_out_data;
        w_we         = 1'b0;
        w_waddr      = r_pend_addr;
        w_wdata      = tccw_pkg::BLANK_CELL;
        w_re         = 1'b0;
        w_raddr      = r_pos;

        // delayed write of a scroll copy or a last-row blank
        if (r_pend_valid) begin
            w_we    = 1'b1;
            w_waddr = r_pend_addr;
            w_wdata = r_pend_copy ? r_rd_data : tccw_pkg::BLANK_CELL;
        end

        case (r_state)
            tccw_pkg::ST_EXEC: begin
                n_scrolled = 1'b0;
                n_res_char = '0;
                n_res_attr = '0;
                case (r_op)
                    tccw_pkg::OP_PUT: begin
                        if (r_char == tccw_pkg::CH_NEWLINE) begin
                            n_base = '0;
                        end else if (r_char == tccw_pkg::CH_TAB) begin
                            n_tab_i = '0;
                        end else if (r_char == tccw_pkg::CH_BACKSPACE) begin
                            if (r_cursor != '0) begin
                                n_cursor = r_cursor - CW'(1);
                                w_we     = 1'b1;
                                w_waddr  = AW'(r_cursor - CW'(1));
                                w_wdata  = {r_attr, tccw_pkg::CH_SPACE};
                            end
                        end else begin
                            n_cursor = r_cursor + CW'(1);
                            w_we     = 1'b1;
                            w_waddr  = AW'(r_cursor);
                            w_wdata  = {r_attr, r_char};
                        end
                    end
                    tccw_pkg::OP_SET: begin
                        n_cursor = CW'(r_pos);
                    end
                    tccw_pkg::OP_CLEAR: begin
                        n_cursor = '0;
                        n_k      = '0;
                        n_emit   = 1'b1;
                    end
                    tccw_pkg::OP_READ: begin
                        w_re    = 1'b1;
                        w_raddr = r_pos;
                    end
                    default: begin
                        n_cursor = r_cursor;
                    end
                endcase
            end
            // row start search, one row a cycle
            tccw_pkg::ST_LINE: begin
                if (w_next_base > r_cursor) begin
                    n_cursor = w_next_base;
                end else begin
                    n_base = w_next_base;
                end
            end
            // tab spaces, dropped past the screen end
            tccw_pkg::ST_TAB: begin
                if (w_tab_addr < CW'(CELL_COUNT)) begin
                    w_we    = 1'b1;
                    w_waddr = AW'(w_tab_addr);
                    w_wdata = {r_attr, tccw_pkg::CH_SPACE};
                end
                n_tab_i = r_tab_i + tccw_pkg::TAB_IW'(1);
                if (r_tab_i == tccw_pkg::TAB_IW'(tccw_pkg::TAB_WIDTH - 1)) begin
                    n_cursor = r_cursor + CW'(tccw_pkg::TAB_WIDTH);
                end
            end
            tccw_pkg::ST_CHECK: begin
                if (r_cursor >= CW'(CELL_COUNT)) begin
                    n_cursor   = r_cursor - CW'(COLUMNS);
                    n_scrolled = 1'b1;
                    n_k        = '0;
                end
            end
            // scroll sweep: read one row ahead, write back next cycle
            tccw_pkg::ST_SCROLL: begin
                n_pend_valid = 1'b1;
                n_pend_addr  = r_k;
                n_pend_copy  = (r_k < AW'(LIMIT));
                if (r_k < AW'(LIMIT)) begin
                    w_re    = 1'b1;
                    w_raddr = r_k + AW'(COLUMNS);
                end
                n_k = r_k + AW'(1);
            end
            // blanking sweep for reset and clear
            tccw_pkg::ST_FILL: begin
                w_we    = 1'b1;
                w_waddr = r_k;
                w_wdata = tccw_pkg::BLANK_CELL;
                n_k     = r_k + AW'(1);
            end
            tccw_pkg::ST_READ: begin
                n_res_char = r_rd_data[7:0];
                n_res_attr = r_rd_data[15:8];
            end
            tccw_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {4'd0, r_scrolled, r_res_attr, r_res_char, 11'(r_cursor)};
                    n_emit      = 1'b0;
                end
            end
            default: begin
                n_k = r_k;
            end
        endcase
    end

    // cursor is back in range whenever a new item can be taken
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tccw_pkg::ST_IDLE) |-> (r_cursor < CW'(CELL_COUNT)))
        else $error("cursor out of range at idle");

    // every memory write stays inside the screen
    a_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (w_waddr < AW'(CELL_COUNT)))
        else $error("memory write outside screen");

    // a scroll write never hits the cell read in the same cycle
    a_scroll_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_valid && w_re) |-> (r_pend_addr != w_raddr))
        else $error("scroll write overlaps read");

    // scrolling only after the flag is set
    a_scroll_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tccw_pkg::ST_SCROLL) |-> r_scrolled)
        else $error("scroll sweep without scroll flag");

    // a result is loaded only from the final state
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid ##1 r_out_valid) |-> ($past(r_state) == tccw_pkg::ST_DONE))
        else $error("result loaded outside final state");

endmodule

@@ dv/text_console_char_writer_unit_test.sv @@
module text_console_char_writer_unit_test;

    localparam int NCOLS  = tccw_pkg::COLUMNS_DEF;
    localparam int NROWS  = tccw_pkg::ROWS_DEF;
    localparam int NCELLS = NCOLS * NROWS;
    localparam int N_RANDOM_CMDS = 930;

    // one console command as carried by an input transfer
    typedef struct packed {
        tccw_pkg::t_op               op;
        logic [tccw_pkg::CHAR_W-1:0] ch;
        logic [tccw_pkg::COL_W-1:0]  fg;
        logic [tccw_pkg::COL_W-1:0]  bg;
        logic [tccw_pkg::POS_W-1:0]  pos;
    } t_console_cmd;

    // one console response as carried by an output transfer
    typedef struct packed {
        logic [tccw_pkg::POS_W-1:0]  cursor;
        logic [tccw_pkg::CHAR_W-1:0] ch;
        logic [tccw_pkg::CHAR_W-1:0] attr;
        logic                        scroll;
    } t_console_resp;

    // screen shadow: tracks cell memory and cursor, predicts each response
    class t_screen_scoreboard;
        logic [tccw_pkg::CELL_W-1:0] cells [NCELLS];
        int unsigned                 cursor;
        t_console_resp               expected_q [$];
        int unsigned                 failures;

        function new();
            foreach (cells[i]) cells[i] = tccw_pkg::BLANK_CELL;
            cursor   = 0;
            failures = 0;
        endfunction

        function void write_cell(int unsigned at, logic [tccw_pkg::CHAR_W-1:0] ch,
                                 logic [tccw_pkg::CHAR_W-1:0] attr);
            if (at < NCELLS) cells[at] = {attr, ch};
        endfunction

        function t_console_resp run_command(t_console_cmd c);
            t_console_resp               r;
            int unsigned                 p;
            logic [tccw_pkg::CHAR_W-1:0] attr;
            r    = '0;
            attr = {c.bg, c.fg};
            // positions past the last cell land on the last cell
            p    = (c.pos >= NCELLS) ? NCELLS - 1 : c.pos;
            case (c.op)
                tccw_pkg::OP_PUT: begin
                    if (c.ch == tccw_pkg::CH_NEWLINE) begin
                        cursor = (cursor / NCOLS + 1) * NCOLS;
                    end else if (c.ch == tccw_pkg::CH_BACKSPACE) begin
                        if (cursor != 0) begin
                            cursor--;
                            write_cell(cursor, tccw_pkg::CH_SPACE, attr);
                        end
                    end else if (c.ch == tccw_pkg::CH_TAB) begin
                        // cells past the screen end are dropped
                        for (int k = 0; k < tccw_pkg::TAB_WIDTH; k++)
                            write_cell(cursor + k, tccw_pkg::CH_SPACE, attr);
                        cursor += tccw_pkg::TAB_WIDTH;
                    end else begin
                        write_cell(cursor, c.ch, attr);
                        cursor++;
                    end
                    // ran off the end: one row up, last row blank
                    if (cursor >= NCELLS) begin
                        for (int k = 0; k < NCELLS - NCOLS; k++) cells[k] = cells[k + NCOLS];
                        for (int k = NCELLS - NCOLS; k < NCELLS; k++)
                            cells[k] = tccw_pkg::BLANK_CELL;
                        cursor  -= NCOLS;
                        r.scroll = 1'b1;
                    end
                end
                tccw_pkg::OP_SET: cursor = p;
                tccw_pkg::OP_CLEAR: begin
                    foreach (cells[i]) cells[i] = tccw_pkg::BLANK_CELL;
                    cursor = 0;
                end
                default: begin
                    r.ch   = cells[p][tccw_pkg::CHAR_W-1:0];
                    r.attr = cells[p][tccw_pkg::CELL_W-1:tccw_pkg::CHAR_W];
                end
            endcase
            r.cursor = cursor[tccw_pkg::POS_W-1:0];
            return r;
        endfunction

        function void note_command(t_console_cmd c);
            expected_q.push_back(run_command(c));
        endfunction

        function void check_result(logic [31:0] data);
            t_console_resp got, want;
            got.cursor = data[10:0];
            got.ch     = data[18:11];
            got.attr   = data[26:19];
            got.scroll = data[27];
            if (expected_q.size() == 0) begin
                if (failures < 10)
                    $display("%0t: unexpected response cursor=%0d char=%h attr=%h scroll=%b",
                             $realtime, got.cursor, got.ch, got.attr, got.scroll);
                failures++;
            end else begin
                want = expected_q.pop_front();
                if (got.cursor !== want.cursor || got.ch !== want.ch ||
                    got.attr !== want.attr || got.scroll !== want.scroll) begin
                    if (failures < 10)
                        $display("%0t: exp/got cursor %0d/%0d ch %h/%h attr %h/%h scr %b/%b",
                                 $realtime,
                                 want.cursor, got.cursor, want.ch, got.ch,
                                 want.attr, got.attr, want.scroll, got.scroll);
                    failures++;
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // character[7:0], fg_color[11:8], bg_color[15:12], position[26:16], zero pad
    logic [31:0] i_s_axis_tdata = '0;
    // operation[1:0]
    logic [1:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // cursor_now[10:0], cell_char[18:11], cell_attr[26:19], did_scroll[27], zero pad
    logic [31:0] o_m_axis_tdata;

    t_screen_scoreboard screen = new();

    int tx_idle_pct = 24;
    int rx_idle_pct = 65;
    int n_results   = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;

    text_console_char_writer_unit #(
        .COLUMNS(NCOLS),
        .ROWS   (NROWS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    initial begin
        #200_000_000;
        $display("FAIL");
        $finish;
    end

    // transfer monitors, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            screen.note_command('{op: tccw_pkg::t_op'(i_s_axis_tuser),
                                  ch: i_s_axis_tdata[7:0],
                                  fg: i_s_axis_tdata[11:8], bg: i_s_axis_tdata[15:12],
                                  pos: i_s_axis_tdata[26:16]});
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            screen.check_result(o_m_axis_tdata);
            n_results++;
        end
    end

    // result side: random stalls plus one long hold-off to back up the block
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_results >= 300) begin
            hold_done <= 1'b1;
            hold_left <= 400;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic t_console_cmd mk_cmd(tccw_pkg::t_op op, int ch, int fg, int bg,
                                            int pos);
        t_console_cmd c;
        c.op  = op;
        c.ch  = ch[tccw_pkg::CHAR_W-1:0];
        c.fg  = fg[tccw_pkg::COL_W-1:0];
        c.bg  = bg[tccw_pkg::COL_W-1:0];
        c.pos = pos[tccw_pkg::POS_W-1:0];
        return c;
    endfunction

    // offer one command, holding valid until the transfer; called at a falling edge
    task automatic send_command(t_console_cmd c);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {5'b0, c.pos, c.bg, c.fg, c.ch};
        i_s_axis_tuser  <= c.op;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic t_console_cmd random_cmd();
        int            pick;
        int            ch;
        tccw_pkg::t_op op;
        int            pos;
        pick = $urandom_range(99);
        if (pick < 70)      op = tccw_pkg::OP_PUT;
        else if (pick < 83) op = tccw_pkg::OP_SET;
        else if (pick < 85) op = tccw_pkg::OP_CLEAR;
        else                op = tccw_pkg::OP_READ;
        pick = $urandom_range(99);
        if (pick < 10)      ch = tccw_pkg::CH_NEWLINE;
        else if (pick < 20) ch = tccw_pkg::CH_BACKSPACE;
        else if (pick < 30) ch = tccw_pkg::CH_TAB;
        else                ch = $urandom_range(255);
        // half of the cursor moves go near the screen end to provoke scrolling
        if (op == tccw_pkg::OP_SET && $urandom_range(1) == 1) pos = $urandom_range(2047, 1840);
        else                                                  pos = $urandom_range(2047);
        return mk_cmd(op, ch, $urandom_range(15), $urandom_range(15), pos);
    endfunction

    // stimulus
    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset contents, field extremes, control characters, scroll, clear
        send_command(mk_cmd(tccw_pkg::OP_READ,  0,       0,   0,   0));
        send_command(mk_cmd(tccw_pkg::OP_PUT,   8'h41,   15,  15,  0));
        send_command(mk_cmd(tccw_pkg::OP_PUT,   0,       0,   0,   2047));
        send_command(mk_cmd(tccw_pkg::OP_PUT,   255,     10,  5,   0));
        send_command(mk_cmd(tccw_pkg::OP_READ,  0,       0,   0,   1));
        send_command(mk_cmd(tccw_pkg::OP_PUT,   tccw_pkg::CH_BACKSPACE, 0, 0, 0));
        send_command(mk_cmd(tccw_pkg::OP_SET,   0,       0,   0,   0));
        send_command(mk_cmd(tccw_pkg::OP_PUT,   tccw_pkg::CH_BACKSPACE, 3, 12, 0));
        send_command(mk_cmd(tccw_pkg::OP_PUT,   tccw_pkg::CH_TAB,  9,   6,   0));
        send_command(mk_cmd(tccw_pkg::OP_PUT,   tccw_pkg::CH_NEWLINE, 0, 0,  0));
        send_command(mk_cmd(tccw_pkg::OP_READ,  0,       0,   0,   3));
        send_command(mk_cmd(tccw_pkg::OP_SET,   0,       0,   0,   2047));
        send_command(mk_cmd(tccw_pkg::OP_PUT,   8'h78,   1,   2,   0));
        send_command(mk_cmd(tccw_pkg::OP_SET,   0,       0,   0,   1998));
        send_command(mk_cmd(tccw_pkg::OP_PUT,   tccw_pkg::CH_TAB,  4,   11,  0));
        send_command(mk_cmd(tccw_pkg::OP_READ,  0,       0,   0,   1918));
        send_command(mk_cmd(tccw_pkg::OP_SET,   0,       0,   0,   1920));
        send_command(mk_cmd(tccw_pkg::OP_PUT,   tccw_pkg::CH_NEWLINE, 0, 0,  0));
        send_command(mk_cmd(tccw_pkg::OP_READ,  0,       0,   0,   2047));
        send_command(mk_cmd(tccw_pkg::OP_SET,   0,       0,   0,   1999));
        send_command(mk_cmd(tccw_pkg::OP_PUT,   tccw_pkg::CH_BACKSPACE, 15, 0, 0));
        send_command(mk_cmd(tccw_pkg::OP_READ,  0,       0,   0,   1998));
        send_command(mk_cmd(tccw_pkg::OP_CLEAR, 0,       0,   0,   0));
        send_command(mk_cmd(tccw_pkg::OP_READ,  0,       0,   0,   5));

        // random, in three idling phases
        for (int n = 0; n < N_RANDOM_CMDS; n++) begin
            if (n == N_RANDOM_CMDS / 3) begin
                tx_idle_pct = 65;
                rx_idle_pct = 24;
            end else if (n == 2 * N_RANDOM_CMDS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            send_command(random_cmd());
        end
        i_s_axis_tvalid <= 1'b0;

        // drain
        while (screen.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (screen.failures == 0 && screen.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/tccw_pkg.sv
hw/rtl/text_console_char_writer_unit.sv
dv/text_console_char_writer_unit_test.sv
